FILE: rtl/dmf_pkg.sv
// Package: shared types and constants for the duplicate and missing finder.
`default_nettype none
package dmf_pkg;

   localparam int MaxItemsDefault = 64;
   localparam int ValueWidth      = 7;

   localparam logic [1:0] CountOne  = 2'd1;
   localparam logic [1:0] CountMany = 2'd2;

   typedef enum logic [1:0] {
      KIND_DUP     = 2'd0,
      KIND_MISSING = 2'd1,
      KIND_NONE    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  last_item;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [ValueWidth-1:0] found_value;
      logic                  last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_en;
      logic scan_miss;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_at_end;
   } stat_type;

endpackage
`default_nettype wire

FILE: rtl/dmf_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module dmf_ram #(
   parameter int Width = 2,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/dmf_ctrl.sv
// Controller: load, two scan passes, drain and finish.
`default_nettype none
module dmf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              last_item,
   input  wire dmf_pkg::stat_type stat,
   output dmf_pkg::cmd_type       cmd,
   output logic                   busy
);
   import dmf_pkg::*;

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_DUP    = 5'b00010,
      ST_MISS   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && last_item) state_in = ST_DUP;
         end
         ST_DUP: begin
            if (stat.scan_at_end) state_in = ST_MISS;
         end
         ST_MISS: begin
            if (stat.scan_at_end) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_LOAD;
         default:   state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.accept    = accept;
      cmd.scan_en   = (state_ff == ST_DUP) || (state_ff == ST_MISS);
      cmd.scan_miss = (state_ff == ST_MISS);
      cmd.finish    = (state_ff == ST_FINISH);
   end

   assign busy = (state_ff != ST_LOAD);

endmodule
`default_nettype wire

FILE: rtl/dmf_datapath.sv
// Datapath: item counter, seen bits, count RAM, scan pipeline and result register.
`default_nettype none
module dmf_datapath #(
   parameter int MaxItems = dmf_pkg::MaxItemsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dmf_pkg::cmd_type cmd,
   input  wire dmf_pkg::req_type req,
   output dmf_pkg::stat_type     stat,
   output logic                  rsp_strobe,
   output dmf_pkg::rsp_type      rsp
);
   import dmf_pkg::*;

   localparam int AddrWidth = $clog2(MaxItems);
   localparam int CntWidth  = $clog2(MaxItems + 1);

   logic [CntWidth-1:0]  items_ff, items_in;
   logic [MaxItems-1:0]  seen_ff, seen_in;
   logic [CntWidth-1:0]  idx_ff, idx_in;

   logic                 eval_vld_ff, eval_miss_ff;
   logic [AddrWidth-1:0] eval_addr_ff;
   logic [CntWidth-1:0]  eval_idx_ff;

   logic                 pend_vld_ff, pend_vld_in;
   rsp_type              pend_ff, pend_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 counted;
   logic [AddrWidth-1:0] wr_addr;
   logic [1:0]           wr_data;
   logic                 wr_en;
   logic [AddrWidth-1:0] rd_addr;
   logic [1:0]           rd_data;
   logic                 hit;
   rsp_type              found;

   // loading: a set bit means seen at least once; the RAM then marks the second sighting
   assign counted = cmd.accept && (items_ff < CntWidth'(MaxItems));
   assign wr_addr = AddrWidth'(req.value - 1'b1);
   assign wr_en   = counted && (req.value != '0) &&
                    (req.value <= ValueWidth'(MaxItems));
   assign wr_data = seen_ff[wr_addr] ? CountMany : CountOne;
   assign rd_addr = AddrWidth'(idx_ff - 1'b1);

   dmf_ram #(
      .Width (2),
      .Depth (MaxItems)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.scan_at_end = (idx_ff == items_ff);

   always_comb begin
      items_in = items_ff;
      seen_in  = seen_ff;
      if (cmd.finish) begin
         items_in = '0;
         seen_in  = '0;
      end else if (counted) begin
         items_in = items_ff + 1'b1;
         if (wr_en) seen_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      if (cmd.scan_en && !stat.scan_at_end) idx_in = idx_ff + 1'b1;
      else if (cmd.scan_en || !cmd.finish)  idx_in = CntWidth'(1);
      else                                  idx_in = idx_ff;
   end

   // evaluate the entry read last cycle
   always_comb begin
      if (eval_miss_ff) hit = eval_vld_ff && !seen_ff[eval_addr_ff];
      else              hit = eval_vld_ff && seen_ff[eval_addr_ff] && (rd_data == CountMany);
      found.kind        = eval_miss_ff ? KIND_MISSING : KIND_DUP;
      found.found_value = ValueWidth'(eval_idx_ff);
      found.last_result = 1'b0;
   end

   // one result is held back so the final one can be flagged
   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      strobe_in   = 1'b0;
      rsp_in      = pend_ff;
      if (cmd.finish) begin
         strobe_in   = 1'b1;
         pend_vld_in = 1'b0;
         if (pend_vld_ff) begin
            rsp_in.last_result = 1'b1;
         end else begin
            rsp_in.kind        = KIND_NONE;
            rsp_in.found_value = '0;
            rsp_in.last_result = 1'b1;
         end
      end else if (hit) begin
         strobe_in   = pend_vld_ff;
         pend_vld_in = 1'b1;
         pend_in     = found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff    <= '0;
         seen_ff     <= '0;
         idx_ff      <= CntWidth'(1);
         eval_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         items_ff    <= items_in;
         seen_ff     <= seen_in;
         idx_ff      <= idx_in;
         eval_vld_ff <= cmd.scan_en;
         pend_vld_ff <= pend_vld_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_miss_ff <= cmd.scan_miss;
      eval_addr_ff <= rd_addr;
      eval_idx_ff  <= idx_ff;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/duplicate_and_missing_finder_top.sv
// Top level of the duplicate and missing finder.
//
// Items of a set enter on req with start; one is taken at each clock edge where
// start is high and busy is low, so a set loads at one item per cycle. The item
// with req.last_item set closes the set; with n the number of items kept (at
// most MAX_ITEMS, later items of the set are dropped) the block then scans
// 1..n twice through the count RAM, one entry per cycle: first for values seen
// twice or more, then for values never seen. busy stays high after the closing
// item through both passes, the drain state and the finish state. Results come
// out on rsp with rsp_strobe high for one cycle each, duplicates first, then
// missing values, both ascending; a set with neither gives a none-found result.
// The last result of a set carries rsp.last_result; it appears as busy drops.
// The receiver cannot stall; results must be taken as they are strobed.
// Reset clears the item count and the seen bits at once, so the block is ready
// as soon as reset drops; the item count and the seen bits are cleared the same
// way after each set.
`default_nettype none
module duplicate_and_missing_finder_top #(
   parameter int MAX_ITEMS = dmf_pkg::MaxItemsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dmf_pkg::req_type req,
   output logic                  rsp_strobe,
   output dmf_pkg::rsp_type      rsp
);
   import dmf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_item (req.last_item),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   dmf_datapath #(
      .MaxItems (MAX_ITEMS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   a_close_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req.last_item |=> busy)
      else $error("closing item did not start the scan");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp.kind == KIND_NONE) |-> rsp.last_result)
      else $error("none-found result not flagged last");

   a_idle_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !busy |-> rsp.last_result)
      else $error("non-final result while loading");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.last_result |=> !rsp_strobe)
      else $error("result follows the final result of a set");

endmodule
`default_nettype wire
